/* sv/gnos_pkg.sv */
// Shared types and constants for the grid neighbour occupancy statistics block.
// Used by gnos_div and grid_neighbour_occupancy_stats_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gnos_pkg;

    // Stream payload widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int CFG_W       = 9;
    localparam int EDGE_W      = 34;
    localparam int CORNER_W    = 34;
    localparam int MEAN_W      = 40;
    localparam int OPEN_W      = 32;
    localparam int OUT_PAY_W   = EDGE_W + CORNER_W + MEAN_W + OPEN_W;
    localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

    // Neighbour count divider: divisor 1..8, remainder below 8
    localparam int DEN_W    = 4;
    localparam int REM_W    = DEN_W - 1;
    localparam int DIV_STEP = 8;

    // Control that travels with a word through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

`default_nettype wire

/* sv/grid_neighbour_occupancy_stats_core.sv */
// Top level: neighbour occupancy statistics over a padded abundance grid in raster order.
// Two line stores in one memory, a 3x3 window, gnos_div for the neighbour mean. Uses gnos_pkg.
//
//   channel     dir   handshake                       payload
//   s_axis      in    i_s_axis_tvalid/o_s_axis_tready  tdata abundance, tuser unsampled
//   m_axis      out   o_m_axis_tvalid/i_m_axis_tready  tdata edge, corner, mean, open
//   cfg         in    i_cfg_valid/o_cfg_ready          interior_size
//
// One cell per cycle unless the final cell is held off. The line store memory is read when a cell
// is accepted and written back the next cycle; the next read is always at another column, so no interlock.
// The final padded cell passes through the accept and window stages and gnos_div before the result word is registered.
// The final cell of a frame is held off while a result waits or is still in the pipeline.
// Synchronous active-low reset clears control state; the line store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbour_occupancy_stats_core #(
    parameter int MAX_SIDE      = 256,
    parameter int VALUE_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [gnos_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [15:0] abundance
    input  wire logic [gnos_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,  // [0] unsampled
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [33:0] edge_sum, [67:34] corner_sum, [107:68] mean_sum, [139:108] open_sum
    output logic [gnos_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [gnos_pkg::CFG_W-1:0]       i_cfg_data
);
    import gnos_pkg::*;

    localparam int LINE_LEN    = MAX_SIDE + 2;
    localparam int CNT_W       = $clog2(LINE_LEN);
    localparam int CELL_W      = VALUE_BITS + 1;
    localparam int ES_W        = VALUE_BITS + 2;
    localparam int S_W         = VALUE_BITS + 3;
    localparam int NUM_W       = S_W + FRACTION_BITS;
    localparam int SIDE_W      = 2 * ES_W + VALUE_BITS;
    localparam int RST_SIDE    = (256 > MAX_SIDE) ? MAX_SIDE : 256;
    localparam int RST_SIDE_M1 = RST_SIDE + 1;

    // Handshakes and frame position
    logic             in_acc;
    logic             cfg_acc;
    logic             frame_end;
    logic [CNT_W-1:0] r_col, r_row, r_side_m1;
    logic [CNT_W-1:0] n_side_m1;
    logic             r_fin_pend;

    // Line store: upper half the row two above, lower half the row above
    logic [2*CELL_W-1:0] r_mem [LINE_LEN];
    logic [2*CELL_W-1:0] r_rd_data;

    // Accept stage
    logic             r_a_valid, r_a_eval, r_a_last;
    logic [CELL_W-1:0] r_a_cell;
    logic [CNT_W-1:0] r_a_col;

    // Window stage
    logic             r_b_valid, r_b_eval, r_b_last;
    logic [CELL_W-1:0] r_win [9];

    // Evaluation
    logic              occ;
    logic [7:0]        smp;
    logic [ES_W-1:0]   es, cs;
    logic [S_W-1:0]    s;
    logic [DEN_W-1:0]  pot;
    logic              take_mean;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [ES_W-1:0]   es_add, cs_add;
    logic [VALUE_BITS-1:0] open_add;
    t_ctl              div_in_ctl, div_out_ctl;
    logic [NUM_W-1:0]  div_quo;
    logic [SIDE_W-1:0] div_side;

    // Totals and result word
    logic [EDGE_W-1:0]   r_edge,   n_edge;
    logic [CORNER_W-1:0] r_corner, n_corner;
    logic [MEAN_W-1:0]   r_mean,   n_mean;
    logic [OPEN_W-1:0]   r_open,   n_open;
    logic [OUT_PAY_W-1:0] r_out;
    logic                r_out_valid;

    assign frame_end       = (r_col == r_side_m1) && (r_row == r_side_m1);
    assign o_s_axis_tready = !(frame_end && (r_out_valid || r_fin_pend));
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign cfg_acc         = i_cfg_valid && o_cfg_ready;

    // Clamp interior size to 1..MAX_SIDE and keep padded side minus one
    always_comb begin
        int unsigned v;
        v = 32'(i_cfg_data);
        if (v == 0) begin
            v = 1;
        end
        if (v > MAX_SIDE) begin
            v = MAX_SIDE;
        end
        n_side_m1 = CNT_W'(v + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_m1 <= CNT_W'(RST_SIDE_M1);
            r_col     <= '0;
            r_row     <= '0;
        end else if (cfg_acc) begin
            r_side_m1 <= n_side_m1;
            r_col     <= '0;
            r_row     <= '0;
        end else if (in_acc) begin
            if (r_col == r_side_m1) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Line store read on accept, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= r_mem[r_col];
        end
        if (r_a_valid) begin
            r_mem[r_a_col] <= {r_rd_data[CELL_W-1:0], r_a_cell};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= in_acc;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cell <= {i_s_axis_tuser[0], VALUE_BITS'(i_s_axis_tdata)};
            r_a_col  <= r_col;
            r_a_eval <= (r_row >= CNT_W'(2)) && (r_col >= CNT_W'(2));
            r_a_last <= frame_end;
        end
        if (r_a_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[3*i]   <= r_win[3*i+1];
                r_win[3*i+1] <= r_win[3*i+2];
            end
            r_win[2] <= r_rd_data[2*CELL_W-1:CELL_W];
            r_win[5] <= r_rd_data[CELL_W-1:0];
            r_win[8] <= r_a_cell;
            r_b_eval <= r_a_eval;
            r_b_last <= r_a_last;
        end
    end

    // Neighbour sums from the window; flag bit marks an unsampled cell
    always_comb begin
        occ    = !r_win[4][VALUE_BITS] && (r_win[4][VALUE_BITS-1:0] != '0);
        smp[0] = !r_win[1][VALUE_BITS];
        smp[1] = !r_win[3][VALUE_BITS];
        smp[2] = !r_win[5][VALUE_BITS];
        smp[3] = !r_win[7][VALUE_BITS];
        smp[4] = !r_win[0][VALUE_BITS];
        smp[5] = !r_win[2][VALUE_BITS];
        smp[6] = !r_win[6][VALUE_BITS];
        smp[7] = !r_win[8][VALUE_BITS];
        es = (smp[0] ? ES_W'(r_win[1][VALUE_BITS-1:0]) : '0)
           + (smp[1] ? ES_W'(r_win[3][VALUE_BITS-1:0]) : '0)
           + (smp[2] ? ES_W'(r_win[5][VALUE_BITS-1:0]) : '0)
           + (smp[3] ? ES_W'(r_win[7][VALUE_BITS-1:0]) : '0);
        cs = (smp[4] ? ES_W'(r_win[0][VALUE_BITS-1:0]) : '0)
           + (smp[5] ? ES_W'(r_win[2][VALUE_BITS-1:0]) : '0)
           + (smp[6] ? ES_W'(r_win[6][VALUE_BITS-1:0]) : '0)
           + (smp[7] ? ES_W'(r_win[8][VALUE_BITS-1:0]) : '0);
        pot       = DEN_W'($countones(smp));
        s         = S_W'(es) + S_W'(cs);
        take_mean = r_b_eval && occ && (pot != '0);
        div_num   = take_mean ? (NUM_W'(s) << FRACTION_BITS) : '0;
        div_den   = take_mean ? pot : DEN_W'(1);
        es_add    = (r_b_eval && occ) ? es : '0;
        cs_add    = (r_b_eval && occ) ? cs : '0;
        open_add  = (take_mean && (s == '0)) ? r_win[4][VALUE_BITS-1:0] : '0;
    end

    assign div_in_ctl = '{valid: r_b_valid, last: r_b_last};

    gnos_div #(
        .NUM_W  (NUM_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_in_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_side  ({open_add, cs_add, es_add}),
        .o_ctl   (div_out_ctl),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    always_comb begin
        n_edge   = r_edge + EDGE_W'(div_side[ES_W-1:0]);
        n_corner = r_corner + CORNER_W'(div_side[2*ES_W-1:ES_W]);
        n_mean   = r_mean + MEAN_W'(div_quo);
        n_open   = r_open + OPEN_W'(div_side[SIDE_W-1:2*ES_W]);
    end

    // Accumulate at the divider output; a cfg write clears; the final cell moves totals to the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge   <= '0;
            r_corner <= '0;
            r_mean   <= '0;
            r_open   <= '0;
        end else if (cfg_acc || (div_out_ctl.valid && div_out_ctl.last)) begin
            r_edge   <= '0;
            r_corner <= '0;
            r_mean   <= '0;
            r_open   <= '0;
        end else if (div_out_ctl.valid) begin
            r_edge   <= n_edge;
            r_corner <= n_corner;
            r_mean   <= n_mean;
            r_open   <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_out_ctl.valid && div_out_ctl.last) begin
            r_out <= {n_open, n_mean, n_corner, n_edge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fin_pend  <= 1'b0;
        end else begin
            if (div_out_ctl.valid && div_out_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && frame_end) begin
                r_fin_pend <= 1'b1;
            end else if (div_out_ctl.valid && div_out_ctl.last) begin
                r_fin_pend <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out);

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_out_ctl.valid && div_out_ctl.last) |-> !r_out_valid)
        else $error("result word overwritten before it was taken");

    a_port_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && in_acc) |-> (r_a_col != r_col))
        else $error("line store read and write hit the same column");

    a_one_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && frame_end) |-> !r_fin_pend)
        else $error("second frame end accepted while one is in flight");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_side_m1) && (r_row <= r_side_m1))
        else $error("frame position outside the padded grid");

endmodule

`default_nettype wire

/* sv/gnos_div.sv */
// Pipelined restoring divider by a small divisor (1..8), DIV_STEP quotient bits per stage.
// Carries a control struct and an opaque side payload alongside. Depends on gnos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gnos_div #(
    parameter int NUM_W  = 27,
    parameter int SIDE_W = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire gnos_pkg::t_ctl             i_ctl,
    input  wire logic [NUM_W-1:0]           i_num,
    input  wire logic [gnos_pkg::DEN_W-1:0] i_den,
    input  wire logic [SIDE_W-1:0]          i_side,
    output gnos_pkg::t_ctl                  o_ctl,
    output logic [NUM_W-1:0]                o_quo,
    output logic [SIDE_W-1:0]               o_side
);
    import gnos_pkg::*;

    localparam int STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;

    // Each stage holds the remaining dividend bits shifted up, quotient bits filling from below
    t_ctl              r_ctl  [STAGES+1];
    logic [NUM_W-1:0]  r_work [STAGES+1];
    logic [REM_W-1:0]  r_rem  [STAGES+1];
    logic [DEN_W-1:0]  r_den  [STAGES+1];
    logic [SIDE_W-1:0] r_side [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work[0] <= i_num;
        r_rem[0]  <= '0;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic [NUM_W-1:0] n_work;
        logic [REM_W-1:0] n_rem;

        always_comb begin
            logic [REM_W:0] t;
            t      = '0;
            n_work = r_work[g];
            n_rem  = r_rem[g];
            for (int b = 0; b < DIV_STEP; b++) begin
                if (g * DIV_STEP + b < NUM_W) begin
                    t      = {n_rem, n_work[NUM_W-1]};
                    n_work = n_work << 1;
                    if (t >= r_den[g]) begin
                        n_rem     = REM_W'(t - r_den[g]);
                        n_work[0] = 1'b1;
                    end else begin
                        n_rem = t[REM_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g+1] <= '0;
            end else begin
                r_ctl[g+1] <= r_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_work[g+1] <= n_work;
            r_rem[g+1]  <= n_rem;
            r_den[g+1]  <= r_den[g];
            r_side[g+1] <= r_side[g];
        end
    end

    assign o_ctl  = r_ctl[STAGES];
    assign o_quo  = r_work[STAGES];
    assign o_side = r_side[STAGES];

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Testbench for grid_neighbour_occupancy_stats_core: streams padded grids, predicts frame totals.
// Depends on gnos_pkg and the core RTL; self-contained, no files or arguments.
`timescale 1ns / 1ps

module tb_top;
    import gnos_pkg::*;

    localparam int MAX_SIDE      = 256;
    localparam int FRAC_BITS     = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic        unsampled;
        logic [15:0] abundance;
    } t_site;

    // Field order matches o_m_axis_tdata from the top bit down
    typedef struct packed {
        logic [OPEN_W-1:0]   open_sum;
        logic [MEAN_W-1:0]   mean_sum;
        logic [CORNER_W-1:0] corner_sum;
        logic [EDGE_W-1:0]   edge_sum;
    } t_stats;

    typedef enum int { RX_OPEN, RX_CHOPPY, RX_SLUGGISH } t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;  // [15:0] abundance
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser = '0;  // [0] unsampled
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [33:0] edge_sum, [67:34] corner_sum, [107:68] mean_sum, [139:108] open_sum
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    grid_neighbour_occupancy_stats_core #(
        .MAX_SIDE      (MAX_SIDE),
        .VALUE_BITS    (16),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Grid model: line stores, window, raster position and running totals
    t_site       line_up2 [0:MAX_SIDE+1];
    t_site       line_up1 [0:MAX_SIDE+1];
    t_site       win [0:8] = '{default: '0};
    int unsigned side_n = MAX_SIDE;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [34:0] edge_acc = '0;
    logic [34:0] corner_acc = '0;
    logic [40:0] mean_acc = '0;
    logic [31:0] open_acc = '0;

    t_stats      frame_stats_q [$];
    int unsigned mismatch_count = 0;
    int unsigned sent_sites = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          gaps_on = 1'b0;
    logic        hold_req = 1'b0;

    function automatic void restart_frame();
        col_pos    = 0;
        row_pos    = 0;
        edge_acc   = '0;
        corner_acc = '0;
        mean_acc   = '0;
        open_acc   = '0;
    endfunction

    // Shift one site into the window; returns 1 when it closes a frame
    function automatic bit advance_grid(input t_site s, output t_stats res);
        t_site       old2;
        t_site       old1;
        logic [19:0] nb_edge;
        logic [19:0] nb_corner;
        logic [19:0] nb_sum;
        logic [3:0]  nb_cnt;
        int          k;

        res  = '0;
        old2 = line_up2[col_pos];
        old1 = line_up1[col_pos];
        line_up2[col_pos] = old1;
        line_up1[col_pos] = s;
        for (k = 0; k < 3; k++) begin
            win[3*k]   = win[3*k+1];
            win[3*k+1] = win[3*k+2];
        end
        win[2] = old2;
        win[5] = old1;
        win[8] = s;

        if (row_pos >= 2 && col_pos >= 2 && !win[4].unsampled && win[4].abundance != 0) begin
            nb_edge   = '0;
            nb_corner = '0;
            nb_cnt    = '0;
            for (k = 0; k < 9; k++) begin
                if (k != 4 && !win[k].unsampled) begin
                    // odd window slots are the edge neighbours
                    if (k % 2 == 1)
                        nb_edge += win[k].abundance;
                    else
                        nb_corner += win[k].abundance;
                    nb_cnt++;
                end
            end
            edge_acc   += nb_edge;
            corner_acc += nb_corner;
            if (nb_cnt != 0) begin
                nb_sum = nb_edge + nb_corner;
                mean_acc += (41'(nb_sum) << FRAC_BITS) / 41'(nb_cnt);
                if (nb_sum == 0)
                    open_acc += win[4].abundance;
            end
        end

        if (col_pos >= side_n + 1) begin
            col_pos = 0;
            if (row_pos >= side_n + 1) begin
                res.edge_sum   = edge_acc[EDGE_W-1:0];
                res.corner_sum = corner_acc[CORNER_W-1:0];
                res.mean_sum   = mean_acc[MEAN_W-1:0];
                res.open_sum   = open_acc;
                restart_frame();
                return 1'b1;
            end
            row_pos++;
        end else begin
            col_pos++;
        end
        return 1'b0;
    endfunction

    function automatic t_site random_site(input int unsigned p_uns, input int unsigned p_zero);
        t_site s;
        s.unsampled = ($urandom_range(0, 7) < p_uns);
        case ($urandom_range(0, 3))
            0:       s.abundance = 16'($urandom_range(1, 15));
            3:       s.abundance = 16'hFFFF;
            default: s.abundance = 16'($urandom);
        endcase
        if ($urandom_range(0, 7) < p_zero)
            s.abundance = '0;
        return s;
    endfunction

    // Offer one word, hold until accepted, then maybe open a gap
    task automatic send_site(input t_site s);
        t_stats res;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s.abundance;
        i_s_axis_tuser  <= s.unsampled;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        if (advance_grid(s, res))
            frame_stats_q.push_back(res);
        sent_sites++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_random_sites(input int unsigned count, input int unsigned p_uns,
                                     input int unsigned p_zero);
        repeat (count) send_site(random_site(p_uns, p_zero));
    endtask

    // Wait for every pending frame result, then let the pipeline empty
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (frame_stats_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        side_n = (val == 0) ? 1 : ((val > MAX_SIDE) ? MAX_SIDE : val);
        restart_frame();
    endtask

    function automatic int unsigned frame_len();
        return (side_n + 2) * (side_n + 2);
    endfunction

    // Part of a frame at the reset size: no word may come out before its end
    task automatic test_reset_size();
        gaps_on = 1'b0;
        send_random_sites(150, 1, 3);
    endtask

    task automatic test_directed();
        t_site pts [0:8];
        int    k;
        write_side(1);
        gaps_on = 1'b0;
        // full-scale neighbours, unsampled ones carry values that must be ignored
        pts = '{{1'b0, 16'hFFFF}, {1'b0, 16'hFFFF}, {1'b1, 16'h1234},
                {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF}, {1'b0, 16'h0001},
                {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b1, 16'hFFFF}};
        for (k = 0; k < 9; k++) send_site(pts[k]);
        // sampled neighbours all empty: centre goes to the open sum
        pts = '{{1'b0, 16'h0000}, {1'b1, 16'hFFFF}, {1'b0, 16'h0000},
                {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b1, 16'h8001},
                {1'b0, 16'h0000}, {1'b0, 16'h0000}, {1'b1, 16'h7FFE}};
        for (k = 0; k < 9; k++) send_site(pts[k]);
        // no sampled neighbour at all: only zero edge and corner sums
        pts = '{{1'b1, 16'hFFFF}, {1'b1, 16'hFFFF}, {1'b1, 16'hFFFF},
                {1'b1, 16'hFFFF}, {1'b0, 16'h0001}, {1'b1, 16'hFFFF},
                {1'b1, 16'hFFFF}, {1'b1, 16'hFFFF}, {1'b1, 16'hFFFF}};
        for (k = 0; k < 9; k++) send_site(pts[k]);
    endtask

    task automatic test_side_limits();
        write_side(0);
        send_random_sites(frame_len(), 2, 2);
        write_side(3);
        send_random_sites(frame_len(), 2, 3);
        write_side(257);
        send_random_sites(20, 1, 2);
        write_side(9'h1FF);
        gaps_on = 1'b0;
        send_random_sites(40, 2, 4);
    endtask

    task automatic test_restart();
        write_side(2);
        gaps_on = 1'b1;
        send_random_sites(10, 1, 2);
        // rewrite mid-frame: partial totals must be dropped
        write_side(2);
        send_random_sites(frame_len(), 1, 2);
        send_random_sites(7, 2, 2);
        write_side(3);
        send_random_sites(frame_len(), 1, 3);
    endtask

    task automatic test_backpressure();
        write_side(1);
        gaps_on  = 1'b0;
        hold_req <= 1'b1;
        send_random_sites(8 * frame_len(), 1, 2);
    endtask

    task automatic test_random_frames();
        int unsigned target;
        int unsigned n;
        int unsigned pick;
        int unsigned p_uns;
        int unsigned p_zero;
        target = sent_sites + 750;
        while (sent_sites < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                n = $urandom_range(1, 4);
            else if (pick < 19)
                n = $urandom_range(5, 8);
            else
                n = $urandom_range(9, 14);
            write_side(n);
            gaps_on = ($urandom_range(0, 3) != 0);
            p_uns   = $urandom_range(0, 6);
            p_zero  = $urandom_range(0, 6);
            if ($urandom_range(0, 7) == 0)
                send_random_sites($urandom_range(1, frame_len() - 1), p_uns, p_zero);
            else
                send_random_sites(frame_len() * $urandom_range(1, 4), p_uns, p_zero);
        end
    endtask

    task automatic check_field(input string name, input logic [MEAN_W-1:0] want,
                               input logic [MEAN_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_stats got;
        t_stats want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_stats'(o_m_axis_tdata[OUT_PAY_W-1:0]);
            if (frame_stats_q.size() == 0) begin
                $error("frame result with no frame pending");
                mismatch_count++;
            end else begin
                want = frame_stats_q.pop_front();
                check_field("edge_sum", want.edge_sum, got.edge_sum);
                check_field("corner_sum", want.corner_sum, got.corner_sum);
                check_field("mean_sum", want.mean_sum, got.mean_sum);
                check_field("open_sum", want.open_sum, got.open_sum);
            end
        end
    end

    // Receiver: long hold on request, otherwise a mode that changes now and then
    always @(posedge i_clk) begin : drive_ready
        static int unsigned hold_left = 0;
        static int unsigned rx_tick = 0;
        static t_rx_mode    rx_mode = RX_OPEN;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req <= 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_tick % 97 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 2));
            case (rx_mode)
                RX_OPEN:     i_m_axis_tready <= 1'b1;
                RX_CHOPPY:   i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_SLUGGISH: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
                default:     i_m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_size();
        test_directed();
        test_side_limits();
        test_restart();
        test_backpressure();
        test_random_frames();
        drain_results();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* grid_neighbour_occupancy_stats_core.f */
sv/gnos_pkg.sv
sv/gnos_div.sv
sv/grid_neighbour_occupancy_stats_core.sv
bench/tb_top.sv
